@@ src/fbpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int HANDLE_W    = 12;
  localparam int LINK_W      = 13;
  localparam int BASE_W      = 14;
  localparam int SIZE_W      = 16;
  localparam int BPC_W       = 9;
  localparam int MC_W        = 5;
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int HANDLE_SPACE = 4096;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(HANDLE_SPACE);
  localparam logic [SIZE_W-1:0] LINK_MIN  = SIZE_W'(8);

  // request modes
  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESIZE = 2'd2;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_BIG  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_CHUNK = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_PER_CHUNK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNKS       = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [SIZE_W-1:0]   request_size;
    logic [HANDLE_W-1:0] handle;
    logic                handle_present;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] result_handle;
  } rsp_t;

  typedef struct packed {
    logic [SIZE_W-1:0] block_size;
    logic [BPC_W-1:0]  blocks_per_chunk;
    logic [MC_W-1:0]   max_chunks;
  } cfg_t;

  typedef struct packed {
    logic                we;
    logic [HANDLE_W-1:0] addr;
    logic [LINK_W-1:0]   data;
  } link_wr_t;

  typedef struct packed {
    logic                re;
    logic [HANDLE_W-1:0] addr;
  } link_rd_t;

endpackage

@@ src/fbpa_if.sv @@
// ----------------------------------------------------------------------------
// fbpa interfaces
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface fbpa_req_if import fbpa_pkg::*;;
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fbpa_rsp_if import fbpa_pkg::*;;
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fbpa_cfg_if import fbpa_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/fbpa_cfg.sv @@
// ----------------------------------------------------------------------------
// fbpa_cfg
// Configuration registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module fbpa_cfg import fbpa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  fbpa_cfg_if.sink   cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.block_size       <= SIZE_W'(8);
      regs.blocks_per_chunk <= BPC_W'(1);
      regs.max_chunks       <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_BLOCK_SIZE:       regs.block_size       <= cfg.data;
        CFG_BLOCKS_PER_CHUNK: regs.blocks_per_chunk <= cfg.data[BPC_W-1:0];
        CFG_MAX_CHUNKS:       regs.max_chunks       <= cfg.data[MC_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ src/fbpa_link_ram.sv @@
// ----------------------------------------------------------------------------
// fbpa_link_ram
// Free-list link memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fbpa_link_ram import fbpa_pkg::*; (
  input  logic              clk,
  input  link_wr_t          wr,
  input  link_rd_t          rd,
  output logic [LINK_W-1:0] rdata
);

  logic [LINK_W-1:0] mem [HANDLE_SPACE];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.re) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

@@ src/fbpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Request sequencer: free-list head, chunk weaving and the result register.
// ----------------------------------------------------------------------------
module fbpa_ctrl import fbpa_pkg::*; #(
  parameter int MAX_CHUNKS           = 16,
  parameter int MAX_BLOCKS_PER_CHUNK = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              regs,
  fbpa_req_if.sink          req,
  fbpa_rsp_if.source        rsp,
  output link_wr_t          link_wr,
  output link_rd_t          link_rd,
  input  logic [LINK_W-1:0] link_rdata,
  output logic              weaving
);

  localparam int CW = $clog2(MAX_CHUNKS + 1);
  localparam int LW = (CW > MC_W) ? CW : MC_W;
  localparam logic [LW-1:0]     CHUNK_CAP = LW'(MAX_CHUNKS);
  localparam logic [LINK_W-1:0] BPC_CAP   = LINK_W'(MAX_BLOCKS_PER_CHUNK);
  localparam logic [BASE_W-1:0] BASE_STEP = BASE_W'(MAX_BLOCKS_PER_CHUNK);
  localparam logic [BASE_W-1:0] BASE_END  = BASE_W'(HANDLE_SPACE);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_POP   = 2'd1;
  localparam logic [1:0] S_WEAVE = 2'd2;
  localparam logic [1:0] S_HOLD  = 2'd3;

  logic [1:0]          state, state_next;
  logic [LINK_W-1:0]   head, head_next;
  logic [CW-1:0]       chunk_count, chunk_count_next;
  logic [BASE_W-1:0]   base, base_next;
  logic [BPC_W-1:0]    widx, widx_next;
  logic [BPC_W-1:0]    n_lat, n_lat_next;
  logic [HANDLE_W-1:0] pop_handle, pop_handle_next;
  logic                out_valid, out_valid_next;
  rsp_t                out_data, out_data_next;
  rsp_t                pend, pend_next;

  logic [SIZE_W-1:0]   eff_bs;
  logic [BPC_W-1:0]    eff_n;
  logic [LW-1:0]       limit;
  logic                too_big;
  logic                is_alloc;
  logic                can_add;
  logic                out_free;
  logic                accept;
  logic                res_go;
  rsp_t                res;
  logic                last;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;
  assign weaving   = (state == S_WEAVE);

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;

  assign eff_bs  = (regs.block_size < LINK_MIN) ? LINK_MIN : regs.block_size;
  assign too_big = req.data.request_size > eff_bs;
  assign is_alloc = (req.data.mode == MODE_ALLOC) ||
                    ((req.data.mode == MODE_RESIZE) && !req.data.handle_present);

  always_comb begin
    if (regs.blocks_per_chunk == '0) begin
      eff_n = BPC_W'(1);
    end else if (BPC_CAP < LINK_W'(regs.blocks_per_chunk)) begin
      eff_n = BPC_CAP[BPC_W-1:0];
    end else begin
      eff_n = regs.blocks_per_chunk;
    end
  end

  assign limit = ((regs.max_chunks == '0) || (LW'(regs.max_chunks) > CHUNK_CAP))
                 ? CHUNK_CAP : LW'(regs.max_chunks);
  assign can_add = (LW'(chunk_count) < limit) && ((base + BASE_W'(eff_n)) <= BASE_END);

  assign last = (widx == n_lat - BPC_W'(1));

  always_comb begin
    state_next       = state;
    head_next        = head;
    chunk_count_next = chunk_count;
    base_next        = base;
    widx_next        = widx;
    n_lat_next       = n_lat;
    pop_handle_next  = pop_handle;
    out_valid_next   = out_valid && !rsp.ready;
    out_data_next    = out_data;
    pend_next        = pend;
    res_go           = 1'b0;
    res              = '{status: ST_OK, result_handle: '0};
    link_wr          = '{we: 1'b0, addr: '0, data: '0};
    link_rd          = '{re: 1'b0, addr: '0};

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.data.mode == MODE_FREE) begin
            // push: old head becomes the link of the freed block
            link_wr   = '{we: 1'b1, addr: req.data.handle, data: head};
            head_next = LINK_W'(req.data.handle);
            res_go    = 1'b1;
          end else if (is_alloc) begin
            if (too_big) begin
              res    = '{status: ST_TOO_BIG, result_handle: '0};
              res_go = 1'b1;
            end else if (head[LINK_W-1]) begin
              if (can_add) begin
                widx_next  = '0;
                n_lat_next = eff_n;
                state_next = S_WEAVE;
              end else begin
                res    = '{status: ST_NO_CHUNK, result_handle: '0};
                res_go = 1'b1;
              end
            end else begin
              link_rd         = '{re: 1'b1, addr: head[HANDLE_W-1:0]};
              pop_handle_next = head[HANDLE_W-1:0];
              state_next      = S_POP;
            end
          end else if (req.data.mode == MODE_RESIZE) begin
            if (too_big) begin
              res = '{status: ST_TOO_BIG, result_handle: '0};
            end else begin
              res = '{status: ST_OK, result_handle: req.data.handle};
            end
            res_go = 1'b1;
          end else begin
            res_go = 1'b1;
          end
        end
      end
      S_POP: begin
        head_next = link_rdata;
        res       = '{status: ST_OK, result_handle: pop_handle};
        res_go    = 1'b1;
      end
      S_WEAVE: begin
        link_wr.we   = 1'b1;
        link_wr.addr = base[HANDLE_W-1:0] + HANDLE_W'(widx);
        link_wr.data = last ? NULL_LINK
                            : LINK_W'(base[HANDLE_W-1:0]) + LINK_W'(widx) + LINK_W'(1);
        widx_next    = widx + BPC_W'(1);
        if (last) begin
          // hand out the first block; its link is known without a read
          head_next        = (n_lat == BPC_W'(1)) ? NULL_LINK
                                                  : LINK_W'(base[HANDLE_W-1:0]) + LINK_W'(1);
          chunk_count_next = chunk_count + CW'(1);
          base_next        = base + BASE_STEP;
          res              = '{status: ST_OK, result_handle: base[HANDLE_W-1:0]};
          res_go           = 1'b1;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_data_next  = pend;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (res_go) begin
      if (out_free) begin
        out_valid_next = 1'b1;
        out_data_next  = res;
        state_next     = S_IDLE;
      end else begin
        pend_next  = res;
        state_next = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head        <= NULL_LINK;
      chunk_count <= '0;
      base        <= '0;
      widx        <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      head        <= head_next;
      chunk_count <= chunk_count_next;
      base        <= base_next;
      widx        <= widx_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    n_lat      <= n_lat_next;
    pop_handle <= pop_handle_next;
    out_data   <= out_data_next;
    pend       <= pend_next;
  end

endmodule

@@ src/fixed_block_pool_allocator.sv @@
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block pool with a LIFO free list kept in a link memory.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                        handshake
//  req      in   mode, request_size, handle, handle_present     valid/ready
//  rsp      out  status, result_handle                          valid/ready
//  cfg      in   index, data (block_size, blocks_per_chunk,     valid/ready
//                max_chunks)
//
//  Free, resize with handle, and every error are decided in the idle state;
//  an allocate served from the free list passes through a pop state for the
//  registered link memory read. An allocate that adds a chunk links n
//  blocks, n the effective blocks per chunk, one link memory write per cycle.
//  Reset is synchronous; the link memory is not cleared and needs no sweep.
//  A new request is taken only when the sequencer is idle; a result waiting
//  in the output register does not block the next request until that
//  request has a result of its own, which is then held.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator import fbpa_pkg::*; #(
  parameter int MAX_CHUNKS           = 16,
  parameter int MAX_BLOCKS_PER_CHUNK = 256
) (
  input  logic        clk,
  input  logic        rst,
  fbpa_req_if.sink    req,
  fbpa_rsp_if.source  rsp,
  fbpa_cfg_if.sink    cfg
);

  cfg_t              regs;
  link_wr_t          link_wr;
  link_rd_t          link_rd;
  logic [LINK_W-1:0] link_rdata;
  logic              weaving;

  fbpa_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  fbpa_link_ram u_ram (
    .clk   (clk),
    .wr    (link_wr),
    .rd    (link_rd),
    .rdata (link_rdata)
  );

  fbpa_ctrl #(
    .MAX_CHUNKS           (MAX_CHUNKS),
    .MAX_BLOCKS_PER_CHUNK (MAX_BLOCKS_PER_CHUNK)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .req        (req),
    .rsp        (rsp),
    .link_wr    (link_wr),
    .link_rd    (link_rd),
    .link_rdata (link_rdata),
    .weaving    (weaving)
  );

  // link memory is written only by a free transfer or while a chunk is linked
  a_link_write: assert property (@(posedge clk) disable iff (rst)
    link_wr.we |-> (req.valid && req.ready && req.data.mode == MODE_FREE) || weaving)
    else $error("link write outside free or chunk linking");

  a_weave_start: assert property (@(posedge clk) disable iff (rst)
    $rose(weaving) |-> $past(req.valid && req.ready))
    else $error("chunk linking started without a request transfer");

  a_link_read: assert property (@(posedge clk) disable iff (rst)
    link_rd.re |-> req.valid && req.ready && !weaving)
    else $error("link read without a request transfer");

  a_err_handle: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.status != ST_OK |-> rsp.data.result_handle == '0)
    else $error("error result carries a nonzero handle");

endmodule
